/* design/rmss_pkg.sv */
// Shared constants, types and state codes for the running median block.
// Used by the stream interfaces, the sorting cell and the top level.
package rmss_pkg;

  // Number of samples the store can hold.
  localparam int CAPACITY = 1024;
  // Width of one sample and of one median.
  localparam int DATA_W = 32;
  // Width of counts and cell positions, wide enough to hold CAPACITY itself.
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // Cell that always holds the lower middle element.
  localparam int MID_POS = (CAPACITY - 1) / 2;
  // Lower edge of the empty store: one above the middle cell.
  localparam int START_EDGE = MID_POS + 1;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Sequencer states: take a word, then form the median.
  typedef enum logic {
    S_IDLE,
    S_CALC
  } state_t;

  // Broadcast control for the row of cells.
  typedef struct packed {
    logic    insert;
    logic    shift_down;
    sample_t sample;
  } cell_ctrl_t;

  // What one cell shows its neighbours.
  typedef struct packed {
    sample_t value;
    logic    above;
    logic    not_above;
  } cell_link_t;

endpackage

/* design/rmss_sample_if.sv */
// Input stream interface carrying one sample per word.
// Depends on rmss_pkg for the sample type.
interface rmss_sample_if;
  logic               valid;
  logic               ready;
  rmss_pkg::sample_t  sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* design/rmss_result_if.sv */
// Output stream interface carrying one median word per sample.
// Depends on rmss_pkg for the sample type.
interface rmss_result_if;
  logic               valid;
  logic               ready;
  rmss_pkg::sample_t  median;
  logic               store_full;

  modport source (output valid, output median, output store_full, input ready);
  modport sink (input valid, input median, input store_full, output ready);
endinterface

/* design/rmss_cell.sv */
// One cell of the sorted store: holds a single sample and takes part in
// insertion by shifting towards or away from the middle. Depends on rmss_pkg.
module rmss_cell (
  input  logic                       clk,
  input  rmss_pkg::cell_ctrl_t       ctrl,
  input  logic [rmss_pkg::CNT_W-1:0] pos,
  input  logic [rmss_pkg::CNT_W-1:0] low_edge,
  input  logic [rmss_pkg::CNT_W-1:0] high_edge,
  input  rmss_pkg::cell_link_t       from_below,
  input  rmss_pkg::cell_link_t       from_above,
  output rmss_pkg::cell_link_t       link
);

  rmss_pkg::sample_t value;
  rmss_pkg::sample_t value_next;
  logic              occupied;
  logic              at_low;
  logic              at_high;
  logic              greater;
  logic              write_en;

  // Occupancy follows from the lower and upper bounds of the stored run.
  assign occupied = (pos >= low_edge) && (pos < high_edge);
  assign at_low   = ((pos + rmss_pkg::CNT_W'(1)) == low_edge);
  assign at_high  = (pos == high_edge);
  assign greater  = value > ctrl.sample;

  assign link.value     = value;
  assign link.above     = occupied && greater;
  assign link.not_above = occupied && !greater;

  // Shifting down moves every value not above the sample one place lower;
  // shifting up moves every value above it one place higher.
  always_comb begin
    if (ctrl.shift_down) begin
      write_en   = link.not_above || at_low;
      value_next = from_above.not_above ? from_above.value : ctrl.sample;
    end else begin
      write_en   = link.above || at_high;
      value_next = from_below.above ? from_below.value : ctrl.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert && write_en) begin
      value <= value_next;
    end
  end

endmodule

/* design/running_median_sorted_store.sv */
// Running median over a stream of signed 32-bit samples. In the cycle a word
// is accepted, the sample is inserted in order across a row of CAPACITY
// cells, each holding one stored value, and then, in the S_CALC state, the
// median is formed from the lower middle cell, or for an even count from the
// two middle cells, into the output register. The stored run is kept centred
// so that the lower middle element always sits in the same cell, which makes
// the median read fixed. When the result register is still held by a stalled
// sink, the block waits in S_CALC. Once CAPACITY samples are stored, further
// samples are dropped and their result carries store_full. No clearing pass
// is needed after reset.
module running_median_sorted_store (
  input  logic          clk,
  input  logic          rst,
  rmss_sample_if.sink   samples,
  rmss_result_if.source medians
);

  localparam int CAP = rmss_pkg::CAPACITY;

  rmss_pkg::state_t            state;
  rmss_pkg::state_t            state_next;
  logic [rmss_pkg::CNT_W-1:0]  count;
  logic [rmss_pkg::CNT_W-1:0]  low_edge;
  logic [rmss_pkg::CNT_W-1:0]  high_edge;
  logic                        full_held;
  logic                        res_valid;
  rmss_pkg::sample_t           res_median;
  logic                        res_full;

  logic                        accept;
  logic                        load_result;
  logic                        is_full;
  rmss_pkg::cell_ctrl_t        cell_ctrl;
  rmss_pkg::cell_link_t        links [CAP];
  rmss_pkg::cell_link_t        below_link [CAP];
  rmss_pkg::cell_link_t        above_link [CAP];
  rmss_pkg::sample_t           mid_lo;
  rmss_pkg::sample_t           mid_hi;
  logic signed [rmss_pkg::DATA_W:0] pair_sum;
  logic signed [rmss_pkg::DATA_W:0] pair_half;
  rmss_pkg::sample_t           median_calc;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rmss_pkg::S_IDLE: begin
        if (samples.valid) state_next = rmss_pkg::S_CALC;
      end
      rmss_pkg::S_CALC: begin
        if (!res_valid || medians.ready) state_next = rmss_pkg::S_IDLE;
      end
      default: state_next = rmss_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    samples.ready = 1'b0;
    load_result   = 1'b0;
    case (state)
      rmss_pkg::S_IDLE: samples.ready = 1'b1;
      rmss_pkg::S_CALC: load_result = !res_valid || medians.ready;
      default: begin
        samples.ready = 1'b0;
        load_result   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign accept  = samples.valid && samples.ready;
  assign is_full = (count == rmss_pkg::CNT_W'(CAP));

  // An even count grows the run downwards so the middle cell stays put.
  assign cell_ctrl.insert     = accept && !is_full;
  assign cell_ctrl.shift_down = !count[0];
  assign cell_ctrl.sample     = samples.sample;

  // Edges of the stored run and the sample count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      low_edge  <= rmss_pkg::CNT_W'(rmss_pkg::START_EDGE);
      high_edge <= rmss_pkg::CNT_W'(rmss_pkg::START_EDGE);
    end else if (cell_ctrl.insert) begin
      count <= count + rmss_pkg::CNT_W'(1);
      if (cell_ctrl.shift_down) begin
        low_edge <= low_edge - rmss_pkg::CNT_W'(1);
      end else begin
        high_edge <= high_edge + rmss_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      full_held <= is_full;
    end
  end

  // Row of cells; the ends see empty neighbours.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign below_link[i] = '0;
    end else begin : g_inner_lo
      assign below_link[i] = links[i-1];
    end
    if (i == CAP - 1) begin : g_last
      assign above_link[i] = '0;
    end else begin : g_inner_hi
      assign above_link[i] = links[i+1];
    end

    rmss_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .pos        (rmss_pkg::CNT_W'(i)),
      .low_edge   (low_edge),
      .high_edge  (high_edge),
      .from_below (below_link[i]),
      .from_above (above_link[i]),
      .link       (links[i])
    );
  end

  // Median from the middle cells; an even pair is halved toward zero.
  assign mid_lo    = links[rmss_pkg::MID_POS].value;
  assign mid_hi    = links[rmss_pkg::MID_POS + 1].value;
  assign pair_sum  = {mid_lo[rmss_pkg::DATA_W-1], mid_lo}
                   + {mid_hi[rmss_pkg::DATA_W-1], mid_hi};
  assign pair_half = (pair_sum >>> 1)
                   + {{rmss_pkg::DATA_W{1'b0}}, pair_sum[rmss_pkg::DATA_W] & pair_sum[0]};

  always_comb begin
    if (count[0]) begin
      median_calc = mid_lo;
    end else begin
      median_calc = pair_half[rmss_pkg::DATA_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_result) begin
      res_valid <= 1'b1;
    end else if (medians.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      res_median <= median_calc;
      res_full   <= full_held;
    end
  end

  assign medians.valid      = res_valid;
  assign medians.median     = res_median;
  assign medians.store_full = res_full;

  // The count always matches the span between the run's edges.
  a_count_span: assert property (@(posedge clk) disable iff (rst)
    count == (high_edge - low_edge))
    else $error("stored count does not match the run edges");

  // The two middle cells stay in order once two samples are stored.
  a_mid_order: assert property (@(posedge clk) disable iff (rst)
    (count >= rmss_pkg::CNT_W'(2)) |-> (mid_lo <= mid_hi))
    else $error("middle cells out of order");

  // A dropped sample is only reported when the store really is full.
  a_full_report: assert property (@(posedge clk) disable iff (rst)
    (medians.valid && medians.store_full) |-> is_full)
    else $error("store_full reported on a store that is not full");

  // With a free output register, S_CALC loads the median and returns to S_IDLE without waiting.
  a_calc_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == rmss_pkg::S_CALC && !res_valid) |=> (state == rmss_pkg::S_IDLE && res_valid))
    else $error("median not loaded after insertion");

endmodule
